// File: design/tse_pkg.sv
package tse_pkg;

  localparam int unsigned FRAC_BITS     = 28;
  localparam int unsigned DEF_MAX_TERMS = 64;

  localparam int unsigned X_W   = 32;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned MAG_W = SUM_W - 1;
  localparam int unsigned TC_W  = 7;
  localparam logic [TC_W-1:0] TC_RESET = TC_W'(50);

  localparam int unsigned CHUNK_W     = 16;
  localparam int unsigned MUL_CHUNKS  = (MAG_W + CHUNK_W) / CHUNK_W;
  localparam int unsigned OPA_W       = CHUNK_W * MUL_CHUNKS;
  localparam int unsigned CHUNK_IDX_W = $clog2(MUL_CHUNKS);
  localparam int unsigned M_W         = 2 * (X_W - 1) - FRAC_BITS + 1;
  localparam int unsigned ACC_W       = OPA_W + M_W;
  localparam int unsigned RND_W       = ACC_W + 1 - FRAC_BITS;

  localparam int unsigned RAD       = 4;
  localparam int unsigned DIV_STEPS = (RND_W + RAD - 1) / RAD;
  localparam int unsigned DVD_W     = DIV_STEPS * RAD;

  localparam int unsigned STEP_W =
    $clog2((DIV_STEPS > MUL_CHUNKS) ? DIV_STEPS : MUL_CHUNKS);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_CHUNKS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT = '0;

  typedef enum logic [1:0] {
    FN_SIN,
    FN_COS,
    FN_EXP,
    FN_NONE
  } fn_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SQR_MUL,
    ST_SQR_SET,
    ST_CHECK,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } st_e;

  typedef struct packed {
    logic                   load;
    logic                   mul_clr;
    logic                   mul_step;
    logic                   mul_sq;
    logic [CHUNK_IDX_W-1:0] chunk;
    logic                   set_m;
    logic                   div_load;
    logic                   div_step;
    logic                   term_upd;
    logic                   res_load;
  } cmd_t;

  typedef struct packed {
    logic is_trig;
    logic is_none;
    logic more;
    logic out_free;
  } sts_t;

endpackage

// File: design/taylor_series_evaluator_core.sv
// Sine and cosine first square x on the shared multiplier; exponential forms its terms directly.
// Term evaluation stops early once a term magnitude rounds to zero.
// Each term takes a pass on the shared 16x35 multiplier and then on the radix-16 divider;
// one request is in work at a time, and the next is taken once the result is loaded.
// Reset (async, active low) idles the controller, drops out_valid_o, term_count goes to 50.
module taylor_series_evaluator_core import tse_pkg::*; #(
  parameter int unsigned MAX_TERMS = DEF_MAX_TERMS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              func_i,
  input  logic signed [X_W-1:0]   x_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SUM_W-1:0] series_sum_o,
  output logic                    overflow_o
);

  logic [TC_W-1:0] term_count;
  cmd_t            cmd;
  sts_t            sts;

  tse_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .term_count_o (term_count)
  );

  tse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tse_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .term_count_i (term_count),
    .func_i       (func_i),
    .x_value_i    (x_value_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .series_sum_o (series_sum_o),
    .overflow_o   (overflow_o)
  );

endmodule

// File: design/tse_cfg.sv
module tse_cfg import tse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [TC_W-1:0]   term_count_o
);

  logic [TC_W-1:0] tc_q, tc_d;
  logic            hit;

  assign hit = (paddr[ADDR_W-1:2] == REG_TERM_COUNT);

  always_comb begin
    tc_d = tc_q;
    if (psel && penable && pwrite && hit) begin
      tc_d = pwdata[TC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= TC_RESET;
    end else begin
      tc_q <= tc_d;
    end
  end

  assign prdata       = hit ? DATA_W'(tc_q) : '0;
  assign pready       = 1'b1;
  assign term_count_o = tc_q;

endmodule

// File: design/tse_ctrl.sv
module tse_ctrl import tse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  st_e               state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        priority if (sts_i.is_none) begin
          state_d = ST_FINISH;
        end else if (sts_i.is_trig) begin
          state_d = ST_SQR_MUL;
          step_d  = MUL_LAST;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_SQR_MUL: begin
        if (step_q == '0) begin
          state_d = ST_SQR_SET;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_SQR_SET: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.more) begin
          state_d = ST_MUL;
          step_d  = MUL_LAST;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_MUL: begin
        if (step_q == '0) begin
          state_d = ST_DIV_LOAD;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_DIV_LOAD: begin
        state_d = ST_DIV;
        step_d  = DIV_LAST;
      end
      ST_DIV: begin
        if (step_q == '0) begin
          state_d = ST_UPDATE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_UPDATE: begin
        state_d = ST_CHECK;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.chunk = step_q[CHUNK_IDX_W-1:0];
    in_stall_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:     cmd_o.load = in_valid_i;
      ST_START:    cmd_o.load = 1'b0;
      ST_SQR_MUL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_sq   = 1'b1;
      end
      ST_SQR_SET:  cmd_o.set_m    = 1'b1;
      ST_CHECK:    cmd_o.mul_clr  = sts_i.more;
      ST_MUL:      cmd_o.mul_step = 1'b1;
      ST_DIV_LOAD: cmd_o.div_load = 1'b1;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_UPDATE:   cmd_o.term_upd = 1'b1;
      ST_FINISH:   cmd_o.res_load = sts_i.out_free;
      default:     cmd_o.load     = 1'b0;
    endcase
  end

endmodule

// File: design/tse_dp.sv
module tse_dp import tse_pkg::*; #(
  parameter int unsigned MAX_TERMS = DEF_MAX_TERMS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic [TC_W-1:0]         term_count_i,
  input  logic [1:0]              func_i,
  input  logic signed [X_W-1:0]   x_value_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic signed [SUM_W-1:0] series_sum_o,
  output logic                    overflow_o
);

  localparam int unsigned A_W   = $clog2(MAX_TERMS + 1);
  localparam int unsigned DEN_W =
    $clog2(4 * (MAX_TERMS - 1) * (MAX_TERMS - 1) + 2 * (MAX_TERMS - 1) + 1);
  localparam int unsigned P_W   = 2 * (A_W + 1);

  localparam logic [MAG_W-1:0] MAG_MAX = '1;
  localparam logic [MAG_W-1:0] ONE_MAG =
    {{(MAG_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W+1:0] SMAX_EXT = $signed({3'b000, MAG_MAX});
  localparam logic signed [SUM_W+1:0] SMIN_EXT = -SMAX_EXT;

  fn_e                     func_q;
  logic                    xneg_q;
  logic [X_W-1:0]          xmag_q;
  logic [A_W-1:0]          n_q, a_q;
  logic [M_W-1:0]          m_q;
  logic [MAG_W-1:0]        tmag_q;
  logic                    tneg_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    ovf_q;
  logic [ACC_W-1:0]        acc_q;
  logic [DVD_W-1:0]        dvd_q;
  logic [DEN_W-1:0]        rem_q, den_q;
  logic                    out_valid_q;
  logic signed [SUM_W-1:0] out_sum_q;
  logic                    out_ovf_q;

  logic                    xneg_in;
  logic [X_W-1:0]          xmag_in;
  logic [A_W-1:0]          n_in;
  logic                    tneg_init;
  logic [MAG_W-1:0]        tmag_init;
  logic signed [SUM_W-1:0] sum_init;

  always_comb begin
    xneg_in   = x_value_i[X_W-1];
    xmag_in   = xneg_in ? (~x_value_i + 1'b1) : x_value_i;
    tneg_init = (fn_e'(func_i) == FN_SIN) && xneg_in;
    tmag_init = (fn_e'(func_i) == FN_SIN) ? MAG_W'(xmag_in) : ONE_MAG;
    sum_init  = tneg_init ? -$signed({1'b0, tmag_init}) : $signed({1'b0, tmag_init});
    priority if (term_count_i == '0) begin
      n_in = A_W'(1);
    end else if (32'(term_count_i) > MAX_TERMS) begin
      n_in = A_W'(MAX_TERMS);
    end else begin
      n_in = A_W'(term_count_i);
    end
  end

  logic [MUL_CHUNKS-1:0][CHUNK_W-1:0] opa;
  logic [M_W-1:0]                     opb;
  logic [CHUNK_W+M_W-1:0]             prod;
  logic [ACC_W-1:0]                   acc_next;
  logic [ACC_W:0]                     rnd_full;
  logic [RND_W-1:0]                   rnd;

  always_comb begin
    opa      = cmd_i.mul_sq ? OPA_W'(xmag_q) : OPA_W'(tmag_q);
    opb      = cmd_i.mul_sq ? M_W'(xmag_q) : m_q;
    prod     = opa[cmd_i.chunk] * opb;
    acc_next = (acc_q << CHUNK_W) + ACC_W'(prod);
    rnd_full = {1'b0, acc_q} + HALF;
    rnd      = rnd_full[ACC_W:FRAC_BITS];
  end

  logic [P_W-1:0]   den_p;
  logic [DEN_W-1:0] den;

  always_comb begin
    den_p = '0;
    den   = '0;
    unique case (func_q)
      FN_SIN: begin
        den_p = P_W'({a_q, 1'b0}) * P_W'({a_q, 1'b1});
        den   = DEN_W'(den_p);
      end
      FN_COS: begin
        den_p = P_W'({a_q - 1'b1, 1'b1}) * P_W'({a_q, 1'b0});
        den   = DEN_W'(den_p);
      end
      FN_EXP:  den = DEN_W'(a_q);
      FN_NONE: den = DEN_W'(1);
    endcase
  end

  logic [DEN_W-1:0] div_r;
  logic [DVD_W-1:0] div_d;
  logic [DEN_W:0]   div_t;

  always_comb begin
    div_r = rem_q;
    div_d = dvd_q;
    div_t = '0;
    for (int i = 0; i < RAD; i++) begin
      div_t = {div_r, div_d[DVD_W-1]};
      div_d = {div_d[DVD_W-2:0], 1'b0};
      if (div_t >= {1'b0, den_q}) begin
        div_t    = div_t - {1'b0, den_q};
        div_d[0] = 1'b1;
      end
      div_r = div_t[DEN_W-1:0];
    end
  end

  logic                    rnd_up;
  logic [DVD_W-1:0]        qr;
  logic                    q_big;
  logic [MAG_W-1:0]        tmag_new;
  logic                    tneg_new;
  logic signed [SUM_W+1:0] term_s, sum_raw;
  logic signed [SUM_W-1:0] sum_new;
  logic                    sum_sat;

  always_comb begin
    rnd_up   = ({rem_q, 1'b0} >= {1'b0, den_q});
    qr       = dvd_q + DVD_W'(rnd_up);
    q_big    = (qr > DVD_W'(MAG_MAX));
    tmag_new = q_big ? MAG_MAX : qr[MAG_W-1:0];
    tneg_new = (func_q == FN_EXP) ? (tneg_q ^ xneg_q) : ~tneg_q;
    term_s   = tneg_new ? -$signed({3'b000, tmag_new}) : $signed({3'b000, tmag_new});
    sum_raw  = $signed({{2{sum_q[SUM_W-1]}}, sum_q}) + term_s;
    priority if (sum_raw > SMAX_EXT) begin
      sum_new = SUM_W'(SMAX_EXT);
      sum_sat = 1'b1;
    end else if (sum_raw < SMIN_EXT) begin
      sum_new = SUM_W'(SMIN_EXT);
      sum_sat = 1'b1;
    end else begin
      sum_new = sum_raw[SUM_W-1:0];
      sum_sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= fn_e'(func_i);
      xneg_q <= xneg_in;
      xmag_q <= xmag_in;
      n_q    <= n_in;
      a_q    <= A_W'(1);
      tmag_q <= tmag_init;
      tneg_q <= tneg_init;
      sum_q  <= sum_init;
      ovf_q  <= 1'b0;
      m_q    <= M_W'(xmag_in);
      acc_q  <= '0;
    end
    if (cmd_i.mul_clr) begin
      acc_q <= '0;
    end
    if (cmd_i.mul_step) begin
      acc_q <= acc_next;
    end
    if (cmd_i.set_m) begin
      m_q <= rnd[M_W-1:0];
    end
    if (cmd_i.div_load) begin
      dvd_q <= DVD_W'(rnd);
      rem_q <= '0;
      den_q <= den;
    end
    if (cmd_i.div_step) begin
      dvd_q <= div_d;
      rem_q <= div_r;
    end
    if (cmd_i.term_upd) begin
      tmag_q <= tmag_new;
      tneg_q <= tneg_new;
      sum_q  <= sum_new;
      ovf_q  <= ovf_q | q_big | sum_sat;
      a_q    <= a_q + 1'b1;
    end
    if (cmd_i.res_load) begin
      out_sum_q <= (func_q == FN_NONE) ? '0 : sum_q;
      out_ovf_q <= (func_q != FN_NONE) && ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      priority if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_trig  = (func_q == FN_SIN) || (func_q == FN_COS);
  assign sts_o.is_none  = (func_q == FN_NONE);
  assign sts_o.more     = (a_q < n_q) && (tmag_q != '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign series_sum_o = out_sum_q;
  assign overflow_o   = out_ovf_q;

endmodule

// File: design/tse_chk.sv
module tse_chk import tse_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [SUM_W-1:0] series_sum_o,
  input logic                    overflow_o
);

  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(series_sum_o) && $stable(overflow_o))
    else $error("stalled result changed");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in work");

  a_sym_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> series_sum_o != SUM_MIN)
    else $error("sum outside symmetric range");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in work");

endmodule

bind taylor_series_evaluator_core tse_chk u_tse_chk (.*);
